@@ design/hlfr_pkg.sv @@
`timescale 1ns / 1ps
// hlfr_pkg: shared types and constants of the header/length frame receiver.
// No dependencies; used by the interfaces and every module of the block.
package hlfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int POS_W       = 5;
    localparam int CFG_IDX_W   = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 8'd1;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'd85;   // 'U'
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'd73;   // 'I'

    // one finished frame handed from the front to the back
    typedef struct packed {
        logic              bank;
        logic [BYTE_W-1:0] hdr0;
        logic [BYTE_W-1:0] hdr1;
        logic [BYTE_W-1:0] length;
    } hlfr_desc_t;

    // payload write into the frame buffer
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [BYTE_W-1:0] pos;
        logic [BYTE_W-1:0] data;
    } hlfr_wr_t;

endpackage

@@ design/hlfr_ifs.sv @@
`timescale 1ns / 1ps
// hlfr_ifs: valid/ready channel interfaces of the frame receiver.
// Depends on hlfr_pkg for the payload widths.
interface hlfr_byte_if import hlfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface hlfr_frame_if import hlfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic [POS_W-1:0]  byte_position;
    logic              last_of_frame;

    modport source (output valid, output frame_byte, output byte_position,
                    output last_of_frame, input ready);
    modport sink (input valid, input frame_byte, input byte_position,
                  input last_of_frame, output ready);
endinterface

interface hlfr_cfg_if import hlfr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/hlfr_front.sv @@
`timescale 1ns / 1ps
// hlfr_front: header hunt, length capture and payload writes; holds the
// header configuration registers. Depends on hlfr_pkg and hlfr_ifs.
module hlfr_front import hlfr_pkg::*; #(
    parameter int MAX_FRAME = 19
) (
    input  logic       clk,
    input  logic       rst_n,
    hlfr_byte_if.sink  rx,
    hlfr_cfg_if.sink   cfg,
    input  logic       q_full,
    output logic       push,
    output hlfr_desc_t desc,
    output hlfr_wr_t   wr
);

    localparam int CW = $clog2(MAX_FRAME + 1);

    typedef enum logic [1:0] {
        P_HUNT = 2'd0,
        P_LEN  = 2'd1,
        P_DATA = 2'd2
    } phase_t;

    phase_t            phase_reg;
    logic [BYTE_W-1:0] prev_reg;
    logic [CW-1:0]     count_reg;
    logic [BYTE_W-1:0] len_reg;
    logic [BYTE_W-1:0] hdr0_reg;
    logic [BYTE_W-1:0] hdr1_reg;
    logic              bank_reg;
    logic [BYTE_W-1:0] header_first_reg;
    logic [BYTE_W-1:0] header_second_reg;

    logic              acc;
    logic [CW-1:0]     cnt_inc;
    logic              done;

    assign rx.ready  = !q_full;
    assign cfg.ready = 1'b1;
    assign acc       = rx.valid && rx.ready;
    assign cnt_inc   = count_reg + CW'(1);
    assign done      = (phase_reg == P_DATA) && (BYTE_W'(cnt_inc) == len_reg);

    assign wr.en   = acc && (phase_reg == P_DATA);
    assign wr.bank = bank_reg;
    assign wr.pos  = BYTE_W'(count_reg);
    assign wr.data = rx.rx_byte;

    assign push        = acc && done;
    assign desc.bank   = bank_reg;
    assign desc.hdr0   = hdr0_reg;
    assign desc.hdr1   = hdr1_reg;
    assign desc.length = len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= P_HUNT;
            prev_reg          <= '0;
            count_reg         <= '0;
            len_reg           <= '0;
            hdr0_reg          <= '0;
            hdr1_reg          <= '0;
            bank_reg          <= 1'b0;
            header_first_reg  <= HEADER_FIRST_RST;
            header_second_reg <= HEADER_SECOND_RST;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_HEADER_FIRST:  header_first_reg  <= cfg.data;
                    REG_HEADER_SECOND: header_second_reg <= cfg.data;
                    default: ;
                endcase
            end
            if (acc)
            begin
                unique case (phase_reg)
                    P_LEN:
                    begin
                        len_reg   <= rx.rx_byte;
                        count_reg <= CW'(3);
                        phase_reg <= P_DATA;
                    end
                    P_DATA:
                    begin
                        count_reg <= cnt_inc;
                        if (done)
                        begin
                            phase_reg <= P_HUNT;
                            bank_reg  <= !bank_reg;
                        end
                        else if (cnt_inc >= CW'(MAX_FRAME))
                            phase_reg <= P_HUNT;   // overlong frame dropped
                    end
                    default:
                    begin
                        // prev byte only tracks while hunting
                        if (prev_reg == header_first_reg && rx.rx_byte == header_second_reg)
                        begin
                            hdr0_reg  <= prev_reg;
                            hdr1_reg  <= rx.rx_byte;
                            count_reg <= CW'(2);
                            phase_reg <= P_LEN;
                        end
                        else
                            phase_reg <= P_HUNT;
                        prev_reg <= rx.rx_byte;
                    end
                endcase
            end
        end
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == P_DATA) |-> (count_reg < CW'(MAX_FRAME)))
        else $error("payload count beyond frame buffer");

endmodule

@@ design/hlfr_desc_fifo.sv @@
`timescale 1ns / 1ps
// hlfr_desc_fifo: two-entry queue of finished-frame descriptors, one per
// buffer bank. Depends on hlfr_pkg.
module hlfr_desc_fifo import hlfr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  hlfr_desc_t push_desc,
    input  logic       pop,
    output hlfr_desc_t head,
    output logic       full,
    output logic       empty
);

    hlfr_desc_t q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign head  = q_reg[rd_ptr_reg];
    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("descriptor push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("descriptor pop while empty");

endmodule

@@ design/hlfr_back.sv @@
`timescale 1ns / 1ps
// hlfr_back: two-bank frame buffer and the byte-by-byte frame emitter.
// Depends on hlfr_pkg and hlfr_ifs.
module hlfr_back import hlfr_pkg::*; #(
    parameter int MAX_FRAME = 19
) (
    input  logic        clk,
    input  logic        rst_n,
    input  hlfr_wr_t    wr,
    input  hlfr_desc_t  head,
    input  logic        q_empty,
    output logic        pop,
    hlfr_frame_if.source frame
);

    localparam int PW    = $clog2(MAX_FRAME);
    localparam int DEPTH = 2 * MAX_FRAME;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_READ = 2'd1,
        B_LOAD = 2'd2,
        B_SEND = 2'd3
    } state_t;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    state_t            state_reg;
    logic [PW-1:0]     pos_reg;
    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [POS_W-1:0]  position_reg;
    logic              last_reg;

    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] pos8;
    logic [BYTE_W-1:0] sel_byte;
    logic              is_last;

    assign wr_addr = wr.bank ? AW'(MAX_FRAME) + AW'(wr.pos) : AW'(wr.pos);
    assign rd_addr = head.bank ? AW'(MAX_FRAME) + AW'(pos_reg) : AW'(pos_reg);
    assign pos8    = BYTE_W'(pos_reg);
    assign is_last = ({1'b0, pos8} + 9'd1) == {1'b0, head.length};

    // header and length come from the descriptor, payload from the buffer
    always_comb
    begin
        if (pos8 == 8'd0)
            sel_byte = head.hdr0;
        else if (pos8 == 8'd1)
            sel_byte = head.hdr1;
        else if (pos8 == 8'd2)
            sel_byte = head.length;
        else
            sel_byte = rd_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr_addr] <= wr.data;
        rd_data_reg <= mem[rd_addr];
    end

    assign pop                 = (state_reg == B_SEND) && frame.ready && last_reg;
    assign frame.valid         = valid_reg;
    assign frame.frame_byte    = byte_reg;
    assign frame.byte_position = position_reg;
    assign frame.last_of_frame = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            pos_reg      <= '0;
            valid_reg    <= 1'b0;
            byte_reg     <= '0;
            position_reg <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        pos_reg   <= '0;
                        state_reg <= B_READ;
                    end
                end
                B_READ:
                    state_reg <= B_LOAD;
                B_LOAD:
                begin
                    byte_reg     <= sel_byte;
                    position_reg <= POS_W'(pos_reg);
                    last_reg     <= is_last;
                    valid_reg    <= 1'b1;
                    state_reg    <= B_SEND;
                end
                B_SEND:
                begin
                    if (frame.ready)
                    begin
                        valid_reg <= 1'b0;
                        if (last_reg)
                            state_reg <= B_IDLE;
                        else
                        begin
                            pos_reg   <= pos_reg + PW'(1);
                            state_reg <= B_READ;
                        end
                    end
                end
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

    a_busy_has_desc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != B_IDLE) |-> !q_empty)
        else $error("emitter busy without a descriptor");

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && frame.ready && frame.last_of_frame) |=> (state_reg == B_IDLE))
        else $error("emitter did not return to idle after last beat");

endmodule

@@ design/header_length_frame_receiver.sv @@
`timescale 1ns / 1ps
// header_length_frame_receiver: top level of the length-prefixed deframer.
// Depends on hlfr_pkg, hlfr_ifs, hlfr_front, hlfr_desc_fifo and hlfr_back.
//
//   port   dir   width                      what moves in one beat
//   rx     in    8                          one received byte (rx_byte)
//   cfg    in    8 index + 8 data           one header register write
//   frame  out   8 + 5 + 1                  one frame byte, position, last flag
//
// A received byte is taken whenever a buffer bank is free.
// The emitter picks up a frame from the descriptor queue, then moves each
// frame byte through buffer read, load and send, and reads the next byte
// only once the sink has taken the current one.
// Two buffer banks: the receive side stalls only while both hold frames
// not yet fully sent. Reset needs no clearing pass; the buffer is not reset.
module header_length_frame_receiver import hlfr_pkg::*; #(
    parameter int MAX_FRAME = 19
) (
    input  logic         clk,
    input  logic         rst_n,
    hlfr_byte_if.sink    rx,
    hlfr_cfg_if.sink     cfg,
    hlfr_frame_if.source frame
);

    hlfr_desc_t push_desc;
    hlfr_desc_t head;
    hlfr_wr_t   wr;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;

    hlfr_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .cfg    (cfg),
        .q_full (q_full),
        .push   (push),
        .desc   (push_desc),
        .wr     (wr)
    );

    hlfr_desc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    hlfr_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .frame   (frame)
    );

endmodule
